FILE: design/fcfs_pkg.sv
// Shared types and codes for the FCFS process scheduler.
package fcfs_pkg;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [1:0] ST_RAN   = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_ADDED = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic        command;
    logic [7:0]  process_id;
    logic [15:0] arr_tick;
    logic [15:0] burst_len;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  served_id;
    logic [15:0] remaining;
    logic        finished;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] arrival;
    logic [15:0] remaining;
  } entry_t;

endpackage

FILE: design/fcfs_entry_ram.sv
// Process table storage: one write port, one read port with registered data.
module fcfs_entry_ram
  import fcfs_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_data
);

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, data valid the cycle after the address is applied
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: design/fcfs_process_scheduler.sv
// Top level of the FCFS process scheduler: command decode, table scan and result register.
//
// The scheduler keeps a table of MAX_PROCESSES process entries (id, arrival time, remaining
// burst) in a synchronous RAM, with one valid flip-flop per slot. An add item stores the
// entry in the lowest free slot and answers "accepted", or answers "full"; an add with zero
// burst is answered "accepted" and stores nothing. A tick item scans every slot for the valid
// entry with the earliest arrival (ties: smaller remaining burst, then lower slot), takes one
// unit off its burst, frees it when the burst hits zero and returns its id. One item is
// worked on at a time. An add passes through S_ADD before the next item is accepted; a tick
// runs a scan that reads one RAM entry per cycle through the single read port, then S_DRAIN
// and S_FIN. Results sit in an output register, so a finished result may wait while the
// next item is accepted and processed; the block only holds before writing a new result
// if the previous one is still stalled.
module fcfs_process_scheduler
  import fcfs_pkg::*;
#(
  parameter int MAX_PROCESSES = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int AW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int CW = $clog2(MAX_PROCESSES + 1);
  localparam logic [CW-1:0] LAST = CW'(MAX_PROCESSES - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_SCAN,
    S_DRAIN,
    S_FIN
  } state_t;

  state_t            state_r, state_nxt;
  in_item_t          req_r, req_nxt;
  logic [MAX_PROCESSES-1:0] valid_r, valid_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;

  // compare stage: slot whose RAM data arrives this cycle
  logic              cmp_on_r, cmp_on_nxt;
  logic [AW-1:0]     cmp_slot_r, cmp_slot_nxt;

  // best entry so far
  logic              found_r, found_nxt;
  logic [31:0]       best_key_r, best_key_nxt;
  logic [7:0]        best_id_r, best_id_nxt;
  logic [AW-1:0]     best_slot_r, best_slot_nxt;

  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_item_r, out_item_nxt;

  // RAM ports
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  entry_t            wr_data;
  entry_t            rd_data;

  logic              free_found;
  logic [AW-1:0]     free_slot;
  logic              out_free;
  logic [31:0]       rd_key;
  logic              take;
  logic [15:0]       rem_dec;

  fcfs_entry_ram #(
    .DEPTH (MAX_PROCESSES),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (cnt_r[AW-1:0]),
    .rd_data (rd_data)
  );

  // lowest free slot from the valid flops
  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = MAX_PROCESSES - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_found = 1'b1;
        free_slot  = AW'(i);
      end
    end
  end

  assign out_free = !out_valid_r || !out_stall;
  // key order: arrival first, then remaining burst; strict less keeps the lower slot on ties
  assign rd_key  = {rd_data.arrival, rd_data.remaining};
  assign take    = cmp_on_r && (!found_r || (rd_key < best_key_r));
  assign rem_dec = best_key_r[15:0] - 16'd1;

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    valid_nxt     = valid_r;
    cnt_nxt       = cnt_r;
    cmp_on_nxt    = 1'b0;
    cmp_slot_nxt  = cnt_r[AW-1:0];
    found_nxt     = found_r;
    best_key_nxt  = best_key_r;
    best_id_nxt   = best_id_r;
    best_slot_nxt = best_slot_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;
    wr_en         = 1'b0;
    wr_addr       = free_slot;
    wr_data       = '{id: req_r.process_id, arrival: req_r.arr_tick,
                      remaining: req_r.burst_len};

    // fold the arriving entry into the running minimum
    if (take) begin
      found_nxt     = 1'b1;
      best_key_nxt  = rd_key;
      best_id_nxt   = rd_data.id;
      best_slot_nxt = cmp_slot_r;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt = in_item;
          if (in_item.command == CMD_TICK) begin
            cnt_nxt   = '0;
            found_nxt = 1'b0;
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_ADD;
          end
        end
      end
      S_ADD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{status: ST_ADDED, served_id: 8'd0, remaining: 16'd0,
                            finished: 1'b0};
          if (req_r.burst_len != 16'd0) begin
            if (free_found) begin
              wr_en              = 1'b1;
              valid_nxt[free_slot] = 1'b1;
            end else begin
              out_item_nxt.status = ST_FULL;
            end
          end
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        // issue one read per cycle; valid flops do not change during the scan
        cmp_on_nxt = valid_r[cnt_r[AW-1:0]];
        cnt_nxt    = cnt_r + CW'(1);
        if (cnt_r == LAST) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (found_r) begin
            wr_en   = 1'b1;
            wr_addr = best_slot_r;
            wr_data = '{id: best_id_r, arrival: best_key_r[31:16], remaining: rem_dec};
            if (rem_dec == 16'd0) begin
              valid_nxt[best_slot_r] = 1'b0;
            end
            out_item_nxt = '{status: ST_RAN, served_id: best_id_r, remaining: rem_dec,
                             finished: (rem_dec == 16'd0)};
          end else begin
            out_item_nxt = '{status: ST_IDLE, served_id: 8'd0, remaining: 16'd0,
                             finished: 1'b0};
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      cnt_r       <= '0;
      cmp_on_r    <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      cnt_r       <= cnt_nxt;
      cmp_on_r    <= cmp_on_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    req_r       <= req_nxt;
    cmp_slot_r  <= cmp_slot_nxt;
    best_key_r  <= best_key_nxt;
    best_id_r   <= best_id_nxt;
    best_slot_r <= best_slot_nxt;
    out_item_r  <= out_item_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

FILE: tb/tb_fcfs_process_scheduler.sv
// Self-checking testbench for the FCFS process scheduler: predictor, driver, monitor, stimulus.
`timescale 1ns / 100ps

module tb_fcfs_process_scheduler;
  import fcfs_pkg::*;

  localparam int SLOTS        = 16;
  localparam int TICK_LATENCY = SLOTS + 3;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 325;
  localparam int CHUNK_ITEMS  = 20;
  localparam int CYCLE_LIMIT  = 500000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  fcfs_process_scheduler #(.MAX_PROCESSES(SLOTS)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  always #5 clk = ~clk;

  // Predicted process table: our own copy of what the block should hold.
  logic        tbl_valid [SLOTS] = '{default: 1'b0};
  logic [7:0]  tbl_id    [SLOTS];
  logic [15:0] tbl_arrival [SLOTS];
  logic [15:0] tbl_left  [SLOTS];

  in_item_t  pending_items[$];
  out_item_t expected_results[$];

  int queued_count   = 0;
  int accepted_count = 0;
  int checked_count  = 0;
  int err_count      = 0;
  int cycle_count    = 0;

  // Outcome tallies for the closing summary.
  int n_ran = 0, n_finished = 0, n_idle = 0, n_added = 0, n_full = 0;

  // Idling knobs, in percent of cycles.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // Long receiver hold-off: the stimulus bumps hold_asked, the hold process counts it out.
  int hold_asked = 0;
  int hold_done  = 0;
  int hold_left  = 0;

  // Set by the monitor at each rising edge when the offered item was taken.
  logic in_taken = 1'b0;

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    err_count++;
  endtask

  // Apply one item to the predicted table and return the result it should produce.
  // Ticks pick the earliest arrival, then the smaller remaining burst, then the lowest slot.
  function automatic out_item_t schedule_step(in_item_t it);
    out_item_t res;
    int pick;
    res  = '0;
    pick = -1;
    if (it.command == CMD_ADD) begin
      res.status = ST_ADDED;
      // A zero-burst add is acknowledged but never stored, even into a full table.
      if (it.burst_len != 16'd0) begin
        for (int s = 0; s < SLOTS; s++) begin
          if (!tbl_valid[s] && pick < 0) pick = s;
        end
        if (pick < 0) begin
          res.status = ST_FULL;
        end else begin
          tbl_valid[pick]   = 1'b1;
          tbl_id[pick]      = it.process_id;
          tbl_arrival[pick] = it.arr_tick;
          tbl_left[pick]    = it.burst_len;
        end
      end
    end else begin
      for (int s = 0; s < SLOTS; s++) begin
        if (tbl_valid[s]) begin
          // Strict compares keep the lower slot on a full tie.
          if (pick < 0 || tbl_arrival[s] < tbl_arrival[pick] ||
              (tbl_arrival[s] == tbl_arrival[pick] && tbl_left[s] < tbl_left[pick])) begin
            pick = s;
          end
        end
      end
      if (pick < 0) begin
        res.status = ST_IDLE;
      end else begin
        tbl_left[pick] = tbl_left[pick] - 16'd1;
        res.status     = ST_RAN;
        res.served_id  = tbl_id[pick];
        res.remaining  = tbl_left[pick];
        res.finished   = (tbl_left[pick] == 16'd0);
        if (res.finished) tbl_valid[pick] = 1'b0;
      end
    end
    return res;
  endfunction

  // Cycle counter and timeout.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               accepted_count - checked_count);
      $display("** fcfs_process_scheduler: FAILED **");
      $finish;
    end
  end

  // Hold process: count out a long receiver hold-off whenever one is asked for.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_done != hold_asked) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= hold_asked;
    end
  end

  // Driver: change inputs at the falling edge only. Hold a stalled item untouched;
  // after an item is taken, offer the next one or idle at random.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_item  <= pending_items.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver side: stall at random, and solidly while a hold-off runs.
  always @(negedge clk) begin
    out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
  end

  // Monitor: predict on every accepted item, then check every accepted result
  // against the oldest prediction, field by field.
  always @(posedge clk) begin
    out_item_t want;
    out_item_t pred;
    in_taken = 1'b0;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        in_taken = 1'b1;
        pred = schedule_step(in_item);
        expected_results.push_back(pred);
        accepted_count++;
        case (pred.status)
          ST_RAN: begin
            n_ran++;
            if (pred.finished) n_finished++;
          end
          ST_IDLE:  n_idle++;
          ST_ADDED: n_added++;
          default:  n_full++;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result (status)", out_item.status, 0);
        end else begin
          want = expected_results.pop_front();
          checked_count++;
          if (out_item.status !== want.status)
            report_mismatch("status", out_item.status, want.status);
          if (out_item.served_id !== want.served_id)
            report_mismatch("served_id", out_item.served_id, want.served_id);
          if (out_item.remaining !== want.remaining)
            report_mismatch("remaining", out_item.remaining, want.remaining);
          if (out_item.finished !== want.finished)
            report_mismatch("finished", out_item.finished, want.finished);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  task automatic queue_item(logic cmd, logic [7:0] pid, logic [15:0] arr, logic [15:0] bur);
    in_item_t it;
    it.command    = cmd;
    it.process_id = pid;
    it.arr_tick   = arr;
    it.burst_len  = bur;
    pending_items.push_back(it);
    queued_count++;
  endtask

  // Random item: adds with short bursts so the table both fills and drains,
  // arrivals often drawn from a small range to force ties. Tick items carry
  // random noise in the fields the block ignores.
  function automatic in_item_t random_item(int add_pct);
    in_item_t it;
    int roll;
    it.command    = ($urandom_range(99) < add_pct) ? CMD_ADD : CMD_TICK;
    it.process_id = 8'($urandom_range(255));
    it.arr_tick   = $urandom_range(1) ? 16'($urandom_range(15)) : 16'($urandom);
    it.burst_len  = 16'($urandom);
    if (it.command == CMD_ADD) begin
      roll = $urandom_range(199);
      if (roll == 0)      it.burst_len = 16'($urandom_range(200, 13));
      else if (roll < 12) it.burst_len = 16'd0;
      else if (roll < 150) it.burst_len = 16'($urandom_range(3, 1));
      else                it.burst_len = 16'($urandom_range(12, 4));
    end
    return it;
  endfunction

  // Wait until every queued item is taken and every expected result has come.
  task automatic wait_drained();
    while (accepted_count != queued_count || checked_count != accepted_count)
      @(negedge clk);
  endtask

  task automatic run_phase(int idle_pct, int stall_pct, bit long_hold);
    int add_pct;
    add_pct = 40;
    @(negedge clk);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    // Ask for the hold-off while the sender keeps offering, so the block backs up.
    if (long_hold) hold_asked++;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      // Switch the add/tick mix every chunk: fill toward full, churn, drain toward idle.
      if (n % CHUNK_ITEMS == 0) begin
        case ($urandom_range(2))
          0:       add_pct = 10;
          1:       add_pct = 40;
          default: add_pct = 85;
        endcase
      end
      pending_items.push_back(random_item(add_pct));
      queued_count++;
    end
    // The stimulus pauses here until all items are taken and all results are back.
    wait_drained();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty tick, zero-burst add, arrival and burst ties, duplicate ids.
    queue_item(CMD_TICK, 8'h00, 16'h0000, 16'h0000);
    queue_item(CMD_ADD,  8'h00, 16'h0000, 16'h0000);
    queue_item(CMD_ADD,  8'h11, 16'd5,    16'd2);
    queue_item(CMD_ADD,  8'h22, 16'd5,    16'd1);
    queue_item(CMD_ADD,  8'h33, 16'd5,    16'd1);
    queue_item(CMD_ADD,  8'h11, 16'd3,    16'd1);
    queue_item(CMD_TICK, 8'hFF, 16'hFFFF, 16'hFFFF);
    queue_item(CMD_TICK, 8'h00, 16'h0000, 16'h0000);
    queue_item(CMD_TICK, 8'h00, 16'h0000, 16'h0000);
    // Fill the rest of the table, then overflow it with all-ones fields,
    // then show a zero-burst add is still accepted while full.
    for (int s = 1; s < SLOTS; s++)
      queue_item(CMD_ADD, 8'(s), 16'(s), 16'd1);
    queue_item(CMD_ADD, 8'hFF, 16'hFFFF, 16'hFFFF);
    queue_item(CMD_ADD, 8'hFF, 16'hFFFF, 16'h0000);
    wait_drained();

    // Random phases with different idling on each side.
    run_phase(0,  0,  1'b1);
    run_phase(63, 0,  1'b0);
    run_phase(0,  63, 1'b0);
    run_phase(14, 14, 1'b0);

    // Let any stray result show up before the verdict.
    repeat (4 * TICK_LATENCY) @(negedge clk);

    $display("covered %0d items: %0d ticks served (%0d finishing), %0d idle ticks,",
             accepted_count, n_ran, n_finished, n_idle);
    $display("  %0d adds accepted, %0d rejected on a full table; %0d mismatches",
             n_added, n_full, err_count);
    if (err_count == 0 && checked_count == accepted_count) begin
      $display("** fcfs_process_scheduler: PASSED **");
    end else begin
      $display("** fcfs_process_scheduler: FAILED **");
    end
    $finish;
  end

endmodule
